// ===== hw/rtl/nbpg_pkg.sv =====
// Shared types, constants and helpers of the pairwise gravity core.
`default_nettype none

package nbpg_pkg;

  localparam int DATA_W            = 32;
  localparam int IDX_W             = 10;
  localparam int DEF_MAX_PARTICLES = 1024;
  localparam logic [DATA_W-1:0] TIME_STEP_RESET = 32'd655;

  // Minimum distance is eight time steps: a left shift by three
  localparam int MIN_DIST_SHIFT = 3;

  // Bit-serial unit lengths
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 42;
  localparam int CNT_W      = 6;
  localparam logic [40:0] Q_CAP = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_PAIR    = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  typedef struct packed {
    func_t                   func;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic signed [DATA_W-1:0] load_pos_x;
    logic signed [DATA_W-1:0] load_pos_y;
    logic signed [DATA_W-1:0] load_vel_x;
    logic signed [DATA_W-1:0] load_vel_y;
    logic [DATA_W-1:0]       load_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_pos_x;
    logic signed [DATA_W-1:0] out_pos_y;
    logic signed [DATA_W-1:0] out_vel_x;
    logic signed [DATA_W-1:0] out_vel_y;
    logic [DATA_W-1:0]       out_mass;
    logic                    saturated;
  } out_item_t;

  // One store entry
  typedef struct packed {
    logic [DATA_W-1:0]        mass;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_x;
  } particle_t;

  // Pair unit results
  typedef struct packed {
    logic signed [DATA_W-1:0] va_x;
    logic signed [DATA_W-1:0] va_y;
    logic signed [DATA_W-1:0] vb_x;
    logic signed [DATA_W-1:0] vb_y;
    logic                     sat;
  } pair_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INDEX, S_WRITE, S_RD_A, S_LAT_A, S_RD_B, S_LAT_B,
    S_CALC, S_WAIT, S_WR_A, S_WR_B, S_ADV_X, S_ADV_Y, S_ADV_WR
  } ctl_state_t;

  typedef enum logic [3:0] {
    C_IDLE, C_SQX, C_SQY, C_SUM, C_SQRT, C_DMIN, C_D2, C_D3A, C_D3B,
    C_D3C, C_K1, C_K2, C_K3, C_K4, C_K5, C_DIV
  } calc_state_t;

  // Clamp to the signed 32-bit range; bit 32 flags a clamp
  function automatic logic [DATA_W:0] sat_clamp(input logic signed [49:0] v);
    logic [DATA_W:0] r;
    if (v > 50'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -50'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nbpg_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module nbpg_ram #(
  parameter int WIDTH = $bits(nbpg_pkg::particle_t),
  parameter int DEPTH = nbpg_pkg::DEF_MAX_PARTICLES
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nbpg_calc.sv =====
// Pair unit: distance square root, cube and four bit-serial velocity kicks.
`default_nettype none

module nbpg_calc (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [31:0]          time_step,
  input  wire nbpg_pkg::particle_t  rec_a,
  input  wire nbpg_pkg::particle_t  rec_b,
  output logic                      done,
  output nbpg_pkg::pair_res_t       res
);

  nbpg_pkg::calc_state_t state_r, state_nxt;

  logic signed [32:0] dx_r, dy_r;
  logic [31:0] mag_dx, mag_dy;
  logic [34:0] mul_a, mul_b;
  logic [69:0] prod_r;
  logic [63:0] sq_r;
  logic [65:0] rad_r;
  logic [34:0] sqrem_r;
  logic [32:0] root_r;
  logic [34:0] d_r, d2hi_r, md;
  logic [104:0] den_r, rem_r;
  logic [31:0] tm_hi_r;
  logic [95:0] num_r;
  logic [111:0] num_sh;
  logic [41:0] nlo_r, q_r;
  logic ovf_r;
  logic [nbpg_pkg::CNT_W-1:0] cnt_r;
  logic [1:0] kick_r;
  logic done_r;
  nbpg_pkg::pair_res_t res_r;

  logic signed [31:0] k_v;
  logic signed [32:0] k_c;
  logic [31:0] k_m, k_cmag;
  logic k_is_a, k_sub;
  logic [36:0] rem4, trial;
  logic sq_ge;
  logic [105:0] rem2;
  logic div_ge;
  logic [40:0] qf;
  logic signed [49:0] app_sum;
  logic [32:0] app_res;

  assign mag_dx = dx_r[32] ? 32'(-dx_r) : dx_r[31:0];
  assign mag_dy = dy_r[32] ? 32'(-dy_r) : dy_r[31:0];
  assign md     = {time_step, 3'b000};
  assign num_sh = {num_r, 16'h0000};

  // Select the operands of the current kick
  always_comb begin
    unique case (kick_r)
      2'd0: begin k_v = rec_a.vel_x; k_c = dx_r; k_m = rec_b.mass; k_is_a = 1'b1; end
      2'd1: begin k_v = rec_a.vel_y; k_c = dy_r; k_m = rec_b.mass; k_is_a = 1'b1; end
      2'd2: begin k_v = rec_b.vel_x; k_c = dx_r; k_m = rec_a.mass; k_is_a = 1'b0; end
      default: begin
        k_v = rec_b.vel_y; k_c = dy_r; k_m = rec_a.mass; k_is_a = 1'b0;
      end
    endcase
    k_cmag = k_c[32] ? 32'(-k_c) : k_c[31:0];
    k_sub  = k_is_a ^ k_c[32];
  end

  // Square root digit step
  assign rem4  = {sqrem_r, rad_r[65:64]};
  assign trial = 37'({root_r, 2'b01});
  assign sq_ge = rem4 >= trial;

  // Restoring divide step
  assign rem2   = {rem_r, nlo_r[41]};
  assign div_ge = rem2 >= {1'b0, den_r};

  // Cap the quotient and apply it with saturation
  always_comb begin
    if (den_r == '0) begin
      qf = '0;
    end else if (ovf_r || (q_r > 42'(nbpg_pkg::Q_CAP))) begin
      qf = nbpg_pkg::Q_CAP;
    end else begin
      qf = q_r[40:0];
    end
    app_sum = k_sub ? (50'(k_v) - $signed({9'b0, qf})) : (50'(k_v) + $signed({9'b0, qf}));
    app_res = nbpg_pkg::sat_clamp(app_sum);
  end

  // Share one multiplier across the square, cube and kick product steps
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      nbpg_pkg::C_SQX: begin mul_a = 35'(mag_dx); mul_b = 35'(mag_dx); end
      nbpg_pkg::C_SQY: begin mul_a = 35'(mag_dy); mul_b = 35'(mag_dy); end
      nbpg_pkg::C_D2:  begin mul_a = d_r;         mul_b = d_r;         end
      nbpg_pkg::C_D3A: begin mul_a = prod_r[34:0]; mul_b = d_r;        end
      nbpg_pkg::C_D3B: begin mul_a = d2hi_r;      mul_b = d_r;         end
      nbpg_pkg::C_K1:  begin mul_a = 35'(time_step); mul_b = 35'(k_m); end
      nbpg_pkg::C_K2:  begin mul_a = 35'(prod_r[31:0]); mul_b = 35'(k_cmag); end
      nbpg_pkg::C_K3:  begin mul_a = 35'(tm_hi_r); mul_b = 35'(k_cmag); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nbpg_pkg::C_IDLE: if (start) begin state_nxt = nbpg_pkg::C_SQX; end
      nbpg_pkg::C_SQX:  state_nxt = nbpg_pkg::C_SQY;
      nbpg_pkg::C_SQY:  state_nxt = nbpg_pkg::C_SUM;
      nbpg_pkg::C_SUM:  state_nxt = nbpg_pkg::C_SQRT;
      nbpg_pkg::C_SQRT: begin
        if (cnt_r == nbpg_pkg::CNT_W'(nbpg_pkg::SQRT_STEPS - 1)) begin
          state_nxt = nbpg_pkg::C_DMIN;
        end
      end
      nbpg_pkg::C_DMIN: state_nxt = nbpg_pkg::C_D2;
      nbpg_pkg::C_D2:   state_nxt = nbpg_pkg::C_D3A;
      nbpg_pkg::C_D3A:  state_nxt = nbpg_pkg::C_D3B;
      nbpg_pkg::C_D3B:  state_nxt = nbpg_pkg::C_D3C;
      nbpg_pkg::C_D3C:  state_nxt = nbpg_pkg::C_K1;
      nbpg_pkg::C_K1:   state_nxt = nbpg_pkg::C_K2;
      nbpg_pkg::C_K2:   state_nxt = nbpg_pkg::C_K3;
      nbpg_pkg::C_K3:   state_nxt = nbpg_pkg::C_K4;
      nbpg_pkg::C_K4:   state_nxt = nbpg_pkg::C_K5;
      nbpg_pkg::C_K5:   state_nxt = nbpg_pkg::C_DIV;
      nbpg_pkg::C_DIV: begin
        // The last pass through the divide state applies the kick instead of a divide step
        if (cnt_r == nbpg_pkg::CNT_W'(nbpg_pkg::DIV_STEPS)) begin
          state_nxt = (kick_r == 2'd3) ? nbpg_pkg::C_IDLE : nbpg_pkg::C_K1;
        end
      end
      default: state_nxt = nbpg_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nbpg_pkg::C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == nbpg_pkg::C_DIV) && (state_nxt == nbpg_pkg::C_IDLE);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 70'(mul_a) * 70'(mul_b);
    unique case (state_r)
      nbpg_pkg::C_IDLE: begin
        dx_r   <= 33'(rec_a.pos_x) - 33'(rec_b.pos_x);
        dy_r   <= 33'(rec_a.pos_y) - 33'(rec_b.pos_y);
        kick_r <= 2'd0;
        // Hold the flag of the last pair until a new one starts
        if (start) begin
          res_r.sat <= 1'b0;
        end
      end
      nbpg_pkg::C_SQY: sq_r <= prod_r[63:0];
      nbpg_pkg::C_SUM: begin
        rad_r   <= 66'(sq_r) + 66'(prod_r[63:0]);
        sqrem_r <= '0;
        root_r  <= '0;
        cnt_r   <= '0;
      end
      nbpg_pkg::C_SQRT: begin
        rad_r <= {rad_r[63:0], 2'b00};
        cnt_r <= cnt_r + 1'b1;
        if (sq_ge) begin
          sqrem_r <= 35'(rem4 - trial);
          root_r  <= {root_r[31:0], 1'b1};
        end else begin
          sqrem_r <= rem4[34:0];
          root_r  <= {root_r[31:0], 1'b0};
        end
      end
      nbpg_pkg::C_DMIN: d_r <= (35'(root_r) < md) ? md : 35'(root_r);
      nbpg_pkg::C_D3A:  d2hi_r <= prod_r[69:35];
      nbpg_pkg::C_D3B:  den_r <= 105'(prod_r);
      nbpg_pkg::C_D3C:  den_r <= den_r + (105'(prod_r) << 35);
      nbpg_pkg::C_K2:   tm_hi_r <= prod_r[63:32];
      nbpg_pkg::C_K3:   num_r <= 96'(prod_r[63:0]);
      nbpg_pkg::C_K4:   num_r <= num_r + (96'(prod_r[63:0]) << 32);
      nbpg_pkg::C_K5: begin
        rem_r <= 105'(num_sh[111:42]);
        nlo_r <= num_sh[41:0];
        ovf_r <= 105'(num_sh[111:42]) >= den_r;
        q_r   <= '0;
        cnt_r <= '0;
      end
      nbpg_pkg::C_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == nbpg_pkg::CNT_W'(nbpg_pkg::DIV_STEPS)) begin
          // Store the kicked velocity and advance to the next component
          unique case (kick_r)
            2'd0: res_r.va_x <= app_res[31:0];
            2'd1: res_r.va_y <= app_res[31:0];
            2'd2: res_r.vb_x <= app_res[31:0];
            default: res_r.vb_y <= app_res[31:0];
          endcase
          res_r.sat <= res_r.sat | app_res[32];
          kick_r    <= kick_r + 1'b1;
        end else begin
          nlo_r <= {nlo_r[40:0], 1'b0};
          q_r   <= {q_r[40:0], div_ge};
          rem_r <= div_ge ? 105'(rem2 - {1'b0, den_r}) : rem2[104:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == nbpg_pkg::C_IDLE) else $error("pair unit started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == nbpg_pkg::C_IDLE && $past(kick_r) == 2'd3))
    else $error("pair unit finished before the fourth kick");
  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nbpg_pkg::C_SQRT |-> cnt_r < nbpg_pkg::CNT_W'(nbpg_pkg::SQRT_STEPS))
    else $error("square root ran past its last digit");

endmodule

`default_nettype wire

// ===== hw/rtl/nbody_pair_gravity_update_core.sv =====
// Top level: particle store, command sequencer, position advance and result port.
//
//  channel | ports                          | handshake
//  input   | start, busy, in_data           | taken when start & !busy
//  result  | out_valid, out_data            | one-cycle strobe, no back pressure
//  config  | cfg_valid, cfg_ready, cfg_data | written when cfg_valid & cfg_ready
//
// One item at a time; a new item is taken only when busy is low.
// The pair time is set mostly by the shared bit-serial divider (one pass per velocity
// component, four components) and the 33-step square root.
// The store is one single-port RAM with registered read; its contents are
// undefined after reset. Reset (rst_n low, synchronous) sets time_step to 655.
// The result appears the cycle after the last step; busy is already low then.
`default_nettype none

module nbody_pair_gravity_update_core #(
  parameter int MAX_PARTICLES = nbpg_pkg::DEF_MAX_PARTICLES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire nbpg_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output nbpg_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_data
);

  localparam int AW = $clog2(MAX_PARTICLES);
  localparam int CW = nbpg_pkg::IDX_W + $clog2(MAX_PARTICLES + 1);
  localparam int RW = $bits(nbpg_pkg::particle_t);

  nbpg_pkg::ctl_state_t state_r, state_nxt;
  nbpg_pkg::in_item_t   item_r;
  nbpg_pkg::particle_t  rec_a_r, rec_b_r, rd_rec, wr_rec;
  nbpg_pkg::out_item_t  out_data_r, out_data_nxt;
  nbpg_pkg::pair_res_t  calc_res;
  logic [AW-1:0] a_addr_r, b_addr_r, ram_addr;
  logic [RW-1:0] ram_rdata;
  logic          ram_we, calc_start, calc_done;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   dt_r;
  logic [63:0]   adv_prod_r;
  logic signed [31:0] adv_v, adv_p, px_r;
  logic          adv_sat_r;
  logic [32:0]   adv_res;
  logic          accept;

  // Reduce a raw index modulo the store depth
  function automatic logic [AW-1:0] idx_mod(input logic [nbpg_pkg::IDX_W-1:0] raw);
    logic [CW-1:0] t;
    t = CW'(raw);
    for (int k = nbpg_pkg::IDX_W - 1; k >= 0; k--) begin
      if (t >= (CW'(MAX_PARTICLES) << k)) begin
        t = t - (CW'(MAX_PARTICLES) << k);
      end
    end
    return t[AW-1:0];
  endfunction

  // Magnitude of a signed component
  function automatic logic [31:0] vmag(input logic signed [31:0] v);
    return v[31] ? 32'(-33'(v)) : v;
  endfunction

  assign accept    = start && !busy;
  assign busy      = state_r != nbpg_pkg::S_IDLE;
  assign cfg_ready = 1'b1;
  assign rd_rec    = ram_rdata;

  // Advance one coordinate by dt * velocity, truncated toward zero
  assign adv_v   = (state_r == nbpg_pkg::S_ADV_Y) ? rec_a_r.vel_x : rec_a_r.vel_y;
  assign adv_p   = (state_r == nbpg_pkg::S_ADV_Y) ? rec_a_r.pos_x : rec_a_r.pos_y;
  assign adv_res = nbpg_pkg::sat_clamp(adv_v[31]
                   ? (50'(adv_p) - $signed({2'b00, adv_prod_r[63:16]}))
                   : (50'(adv_p) + $signed({2'b00, adv_prod_r[63:16]})));

  nbpg_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_rec),
    .rdata (ram_rdata)
  );

  nbpg_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (calc_start),
    .time_step (dt_r),
    .rec_a     (rec_a_r),
    .rec_b     (rec_b_r),
    .done      (calc_done),
    .res       (calc_res)
  );

  // Sequence store accesses and build the result
  always_comb begin
    state_nxt     = state_r;
    ram_we        = 1'b0;
    ram_addr      = a_addr_r;
    wr_rec        = rec_a_r;
    calc_start    = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      nbpg_pkg::S_IDLE: if (accept) begin state_nxt = nbpg_pkg::S_INDEX; end
      nbpg_pkg::S_INDEX: begin
        state_nxt = (item_r.func == nbpg_pkg::FUNC_WRITE) ? nbpg_pkg::S_WRITE
                                                           : nbpg_pkg::S_RD_A;
      end
      nbpg_pkg::S_WRITE: begin
        ram_we        = 1'b1;
        wr_rec        = '{mass: item_r.load_mass, vel_y: item_r.load_vel_y,
                          vel_x: item_r.load_vel_x, pos_y: item_r.load_pos_y,
                          pos_x: item_r.load_pos_x};
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_pos_x: item_r.load_pos_x, out_pos_y: item_r.load_pos_y,
                          out_vel_x: item_r.load_vel_x, out_vel_y: item_r.load_vel_y,
                          out_mass: item_r.load_mass, saturated: 1'b0};
        state_nxt     = nbpg_pkg::S_IDLE;
      end
      nbpg_pkg::S_RD_A: begin
        state_nxt = (item_r.func == nbpg_pkg::FUNC_PAIR) ? nbpg_pkg::S_RD_B
                                                          : nbpg_pkg::S_LAT_A;
      end
      nbpg_pkg::S_LAT_A: begin
        if (item_r.func == nbpg_pkg::FUNC_ADVANCE) begin
          state_nxt = nbpg_pkg::S_ADV_X;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_pos_x: rd_rec.pos_x, out_pos_y: rd_rec.pos_y,
                            out_vel_x: rd_rec.vel_x, out_vel_y: rd_rec.vel_y,
                            out_mass: rd_rec.mass, saturated: 1'b0};
          state_nxt     = nbpg_pkg::S_IDLE;
        end
      end
      nbpg_pkg::S_RD_B: begin
        ram_addr  = b_addr_r;
        state_nxt = nbpg_pkg::S_LAT_B;
      end
      nbpg_pkg::S_LAT_B: state_nxt = nbpg_pkg::S_CALC;
      nbpg_pkg::S_CALC: begin
        calc_start = 1'b1;
        state_nxt  = nbpg_pkg::S_WAIT;
      end
      nbpg_pkg::S_WAIT: if (calc_done) begin state_nxt = nbpg_pkg::S_WR_A; end
      nbpg_pkg::S_WR_A: begin
        ram_we       = 1'b1;
        wr_rec.vel_x = calc_res.va_x;
        wr_rec.vel_y = calc_res.va_y;
        state_nxt    = nbpg_pkg::S_WR_B;
      end
      nbpg_pkg::S_WR_B: begin
        ram_we        = 1'b1;
        ram_addr      = b_addr_r;
        wr_rec        = rec_b_r;
        wr_rec.vel_x  = calc_res.vb_x;
        wr_rec.vel_y  = calc_res.vb_y;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_pos_x: rec_a_r.pos_x, out_pos_y: rec_a_r.pos_y,
                          out_vel_x: calc_res.va_x, out_vel_y: calc_res.va_y,
                          out_mass: rec_a_r.mass, saturated: calc_res.sat};
        state_nxt     = nbpg_pkg::S_IDLE;
      end
      nbpg_pkg::S_ADV_X: state_nxt = nbpg_pkg::S_ADV_Y;
      nbpg_pkg::S_ADV_Y: state_nxt = nbpg_pkg::S_ADV_WR;
      nbpg_pkg::S_ADV_WR: begin
        ram_we        = 1'b1;
        wr_rec.pos_x  = px_r;
        wr_rec.pos_y  = adv_res[31:0];
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_pos_x: px_r, out_pos_y: adv_res[31:0],
                          out_vel_x: rec_a_r.vel_x, out_vel_y: rec_a_r.vel_y,
                          out_mass: rec_a_r.mass, saturated: adv_sat_r | adv_res[32]};
        state_nxt     = nbpg_pkg::S_IDLE;
      end
      default: state_nxt = nbpg_pkg::S_IDLE;
    endcase
  end

  // Control state and the time step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nbpg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      dt_r        <= nbpg_pkg::TIME_STEP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        dt_r <= cfg_data;
      end
    end
  end

  // Capture item, addresses, records and advance products
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == nbpg_pkg::S_INDEX) begin
      a_addr_r <= idx_mod(item_r.first_index);
      b_addr_r <= idx_mod(item_r.second_index);
    end
    if (state_r == nbpg_pkg::S_LAT_A || state_r == nbpg_pkg::S_RD_B) begin
      rec_a_r <= rd_rec;
    end
    if (state_r == nbpg_pkg::S_LAT_B) begin
      rec_b_r <= rd_rec;
    end
    if (state_r == nbpg_pkg::S_ADV_X) begin
      adv_prod_r <= 64'(dt_r) * 64'(vmag(rec_a_r.vel_x));
    end
    if (state_r == nbpg_pkg::S_ADV_Y) begin
      px_r       <= adv_res[31:0];
      adv_sat_r  <= adv_res[32];
      adv_prod_r <= 64'(dt_r) * 64'(vmag(rec_a_r.vel_y));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe held for two cycles");
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy)) else $error("result without an item in progress");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    calc_done |-> state_r == nbpg_pkg::S_WAIT) else $error("pair unit done out of turn");
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> busy) else $error("store written while idle");

endmodule

`default_nettype wire

// ===== test/nbody_pair_gravity_update_core_test.sv =====
// Self-checking testbench for the pairwise gravity core: a predictor per item, random idling.
`default_nettype none

module nbody_pair_gravity_update_core_test;
  import nbpg_pkg::*;

  localparam int LIMIT = 2000000;
  localparam logic [127:0] Q_MAX = 128'h100_0000_0000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;

  nbody_pair_gravity_update_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predicted particle store and time step
  logic signed [31:0] px [1024];
  logic signed [31:0] py [1024];
  logic signed [31:0] vx [1024];
  logic signed [31:0] vy [1024];
  logic [31:0] mass [1024];
  bit written [1024];
  int written_list[$];
  logic [31:0] dt;

  out_item_t pending_results[$];
  int errors;
  int cycles;
  int gap_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Clamp to signed 32 bits; bit 32 flags a clamp
  function automatic logic [32:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Velocity change dt*m*|c|*2^16/den applied in direction dir
  function automatic logic [32:0] velocity_kick(input logic signed [63:0] v,
      input logic signed [63:0] c, input logic [31:0] m, input logic [127:0] den,
      input int dir);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] t;
    logic [127:0] mm;
    logic [127:0] cc;
    int s;
    t = {96'b0, dt};
    mm = {96'b0, m};
    cc = {64'b0, magnitude(c)};
    num = (t * mm * cc) << 16;
    q = (den == 0) ? 128'd0 : num / den;
    if (q > Q_MAX) q = Q_MAX;
    s = (c < 0) ? -dir : dir;
    return clamp32(s > 0 ? v + $signed(q[63:0]) : v - $signed(q[63:0]));
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    logic [127:0] c2;
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (64'd1 << b);
      c2 = {64'b0, c} * {64'b0, c};
      if (c2 <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [32:0] advance_pos(input logic signed [31:0] p,
      input logic signed [31:0] v);
    logic [63:0] m;
    m = ({32'b0, dt} * magnitude(64'(v))) >> 16;
    return clamp32(v < 0 ? 64'(p) - $signed(m) : 64'(p) + $signed(m));
  endfunction

  // Apply one item to the predicted store and queue its result
  task automatic predict_gravity_step(input in_item_t it);
    int a;
    int b;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [63:0] d;
    logic [63:0] md;
    logic [127:0] den;
    logic [127:0] ssq;
    logic [32:0] r0;
    logic [32:0] r1;
    logic [32:0] r2;
    logic [32:0] r3;
    out_item_t res;
    logic sat;
    a = it.first_index;
    b = it.second_index;
    sat = 1'b0;
    case (it.func)
      FUNC_WRITE: begin
        px[a] = it.load_pos_x;
        py[a] = it.load_pos_y;
        vx[a] = it.load_vel_x;
        vy[a] = it.load_vel_y;
        mass[a] = it.load_mass;
        if (!written[a]) written_list.push_back(a);
        written[a] = 1'b1;
      end
      FUNC_PAIR: begin
        dx = 64'(px[a]) - 64'(px[b]);
        dy = 64'(py[a]) - 64'(py[b]);
        ssq = {64'b0, magnitude(dx)} * {64'b0, magnitude(dx)}
            + {64'b0, magnitude(dy)} * {64'b0, magnitude(dy)};
        d = floor_sqrt(ssq);
        md = {32'b0, dt} << MIN_DIST_SHIFT;
        if (d < md) d = md;
        den = {64'b0, d} * {64'b0, d} * {64'b0, d};
        r0 = velocity_kick(64'(vx[a]), dx, mass[b], den, -1);
        r1 = velocity_kick(64'(vy[a]), dy, mass[b], den, -1);
        r2 = velocity_kick(64'(vx[b]), dx, mass[a], den, 1);
        r3 = velocity_kick(64'(vy[b]), dy, mass[a], den, 1);
        sat = r0[32] | r1[32] | r2[32] | r3[32];
        // Particle a first, then b, so b wins when they coincide
        vx[a] = r0[31:0];
        vy[a] = r1[31:0];
        vx[b] = r2[31:0];
        vy[b] = r3[31:0];
      end
      FUNC_ADVANCE: begin
        r0 = advance_pos(px[a], vx[a]);
        r1 = advance_pos(py[a], vy[a]);
        sat = r0[32] | r1[32];
        px[a] = r0[31:0];
        py[a] = r1[31:0];
      end
      default: ;
    endcase
    res.out_pos_x = px[a];
    res.out_pos_y = py[a];
    res.out_vel_x = vx[a];
    res.out_vel_y = vy[a];
    res.out_mass = mass[a];
    res.saturated = sat;
    pending_results.push_back(res);
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.out_pos_x !== e.out_pos_x) begin
          $display("%0t: pos_x exp %h got %h", $time, e.out_pos_x, out_data.out_pos_x);
          errors++;
        end
        if (out_data.out_pos_y !== e.out_pos_y) begin
          $display("%0t: pos_y exp %h got %h", $time, e.out_pos_y, out_data.out_pos_y);
          errors++;
        end
        if (out_data.out_vel_x !== e.out_vel_x) begin
          $display("%0t: vel_x exp %h got %h", $time, e.out_vel_x, out_data.out_vel_x);
          errors++;
        end
        if (out_data.out_vel_y !== e.out_vel_y) begin
          $display("%0t: vel_y exp %h got %h", $time, e.out_vel_y, out_data.out_vel_y);
          errors++;
        end
        if (out_data.out_mass !== e.out_mass) begin
          $display("%0t: mass exp %h got %h", $time, e.out_mass, out_data.out_mass);
          errors++;
        end
        if (out_data.saturated !== e.saturated) begin
          $display("%0t: saturated exp %b got %b", $time, e.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // Present one item and hold it until taken; start stays high for a follow-on item unless a random gap is drawn
  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    predict_gravity_step(it);
    if (($urandom % 100) < gap_pct) begin
      start <= 1'b0;
      in_data <= '0;
      do @(posedge clk); while (($urandom % 100) < gap_pct);
    end
  endtask

  // Hold off until every predicted result has come, then let the core settle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_time_step(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dt = v;
  endtask

  function automatic in_item_t make_item(input func_t f, input int a, input int b,
      input logic [31:0] x, input logic [31:0] y, input logic [31:0] ux,
      input logic [31:0] uy, input logic [31:0] m);
    in_item_t it;
    it.func = f;
    it.first_index = a[9:0];
    it.second_index = b[9:0];
    it.load_pos_x = x;
    it.load_pos_y = y;
    it.load_vel_x = ux;
    it.load_vel_y = uy;
    it.load_mass = m;
    return it;
  endfunction

  // Mix of full-range, near-origin and extreme values
  function automatic logic [31:0] rand_value();
    case ($urandom % 6)
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
      3: return 32'($signed($urandom_range(0, 200000)) - 100000);
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 64)) - 32) << 12;
    endcase
  endfunction

  function automatic int pick_written();
    return written_list[$urandom % written_list.size()];
  endfunction

  // Extremes of each field, every operation
  task automatic test_extremes();
    send_item(make_item(FUNC_WRITE, 0, 1023, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_WRITE, 1023, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_item(make_item(FUNC_WRITE, 1, 512, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000));
    send_item(make_item(FUNC_WRITE, 2, 341, 32'h0000_2000, 32'h0, 32'h7FFF_0000,
                        32'h8001_0000, 32'hFFFF_FFFF));
    send_item(make_item(FUNC_READ, 0, 1023, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_READ, 1023, 682, '1, '1, '1, '1, '1));
    send_item(make_item(FUNC_PAIR, 0, 1023, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_PAIR, 1023, 0, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_PAIR, 1, 2, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_PAIR, 2, 1, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_ADVANCE, 0, 5, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_ADVANCE, 1023, 5, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_ADVANCE, 2, 5, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_READ, 2, 0, '0, '0, '0, '0, '0));
  endtask

  // Same particle twice, coincident particles, zero time step
  task automatic test_special_cases();
    send_item(make_item(FUNC_PAIR, 2, 2, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_WRITE, 3, 0, 32'h0001_0000, 32'h0001_0000,
                        32'h0000_0100, 32'hFFFF_FF00, 32'h0100_0000));
    send_item(make_item(FUNC_WRITE, 4, 0, 32'h0001_0000, 32'h0001_0000,
                        32'h0, 32'h0, 32'h0200_0000));
    send_item(make_item(FUNC_PAIR, 3, 4, '0, '0, '0, '0, '0));
    write_time_step(32'h0);
    send_item(make_item(FUNC_PAIR, 3, 4, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_PAIR, 1, 2, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_ADVANCE, 2, 0, '0, '0, '0, '0, '0));
    send_item(make_item(FUNC_PAIR, 2, 2, '0, '0, '0, '0, '0));
  endtask

  // Random well-formed traffic over a small reused pool, with some full-range writes
  task automatic test_random_traffic(input int n);
    in_item_t it;
    int r;
    int a;
    for (int k = 0; k < n; k++) begin
      r = $urandom % 100;
      if (r < 20 || written_list.size() < 2) begin
        a = ($urandom % 4 == 0) ? int'($urandom % 1024)
                                : ($urandom_range(0, 1) ? $urandom % 16 : 1008 + $urandom % 16);
        it = make_item(FUNC_WRITE, a, $urandom, rand_value(), rand_value(), rand_value(),
                       rand_value(), ($urandom % 3 == 0) ? $urandom : rand_value());
      end else if (r < 60) begin
        it = make_item(FUNC_PAIR, pick_written(), pick_written(), $urandom, $urandom,
                       $urandom, $urandom, $urandom);
      end else if (r < 85) begin
        it = make_item(FUNC_ADVANCE, pick_written(), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
      end else begin
        it = make_item(FUNC_READ, pick_written(), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
      end
      send_item(it);
    end
  endtask

  // Sweep the time step across idle phases
  task automatic test_time_steps();
    logic [31:0] steps [6];
    steps = '{32'd1, 32'hFFFF_FFFF, TIME_STEP_RESET, 32'h0001_0000, 32'd0, 32'd655};
    for (int i = 0; i < 6; i++) begin
      write_time_step(i == 3 ? $urandom : steps[i]);
      gap_pct = (i % 3 == 0) ? 0 : (i % 3 == 1) ? 87 : 13;
      test_random_traffic(110);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    gap_pct = 0;
    dt = TIME_STEP_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    write_time_step(TIME_STEP_RESET);
    gap_pct = 87;
    test_random_traffic(40);
    drain();
    test_time_steps();
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
